### rtl/shcwb_pkg.sv
// Shared constants, codes and types for the shadow copy write-back block.
`default_nettype none
package shcwb_pkg;

  localparam int IMAGE_BYTES = 128;
  localparam int IDX_W       = (IMAGE_BYTES > 1) ? $clog2(IMAGE_BYTES) : 1;
  localparam int ADDR_W      = 7;
  localparam int BYTE_W      = 8;

  localparam logic [IDX_W-1:0]  LAST_POS    = IDX_W'(IMAGE_BYTES - 1);
  localparam logic [BYTE_W-1:0] BYTE_ERASED = {BYTE_W{1'b1}};

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_STORE = 2'd1,
    OP_READY = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCAN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              status;
    logic              nv_write_valid;
    logic [ADDR_W-1:0] nv_write_addr;
    logic [BYTE_W-1:0] nv_write_data;
    logic              store_done;
    logic              busy_res;
    logic [BYTE_W-1:0] read_data;
  } res_t;

endpackage
`default_nettype wire

### rtl/shcwb_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none
module shcwb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/shadow_copy_write_back.sv
// Top level: working/stored image copies with scan-and-write-back sequencer.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | op, addr, data
//  out     | out_valid / out_ready| status, nv_write_valid, nv_write_addr,
//          |                      | nv_write_data, store_done, busy_res,
//          |                      | read_data
//
// After reset a clearing pass writes 0xFF into both image RAMs, one byte per
// cycle; in_ready stays low until it ends. Write and store ops go through EXEC
// and FIN to the result register; a read adds READ for the registered RAM read
// port. A ready event during a store adds SCAN, comparing positions one per
// cycle via the RAM read ports until a mismatch or the last position.
// One item is in flight at a time; the next one is taken while the previous
// result still sits in the output register. A stalled output holds the
// sequencer in its final state until the result register frees up.
`default_nettype none
module shadow_copy_write_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 op,
  input  wire logic [shcwb_pkg::ADDR_W-1:0] addr,
  input  wire logic [shcwb_pkg::BYTE_W-1:0] data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            status,
  output logic                            nv_write_valid,
  output logic [shcwb_pkg::ADDR_W-1:0]    nv_write_addr,
  output logic [shcwb_pkg::BYTE_W-1:0]    nv_write_data,
  output logic                            store_done,
  output logic                            busy_res,
  output logic [shcwb_pkg::BYTE_W-1:0]    read_data
);
  import shcwb_pkg::*;

  // control state
  state_t           state, state_next;
  logic [IDX_W-1:0] clr_idx, clr_idx_next;
  logic [IDX_W-1:0] pos, pos_next;      // scan position
  logic             busy, busy_next;    // store in progress

  // latched item
  op_t               op_r;
  logic [IDX_W-1:0]  idx_r;
  logic              addr_ok_r;
  logic [BYTE_W-1:0] data_r;

  // result under construction and output register
  res_t res, res_next;
  res_t out_res;
  logic out_valid_next;
  logic out_load;

  // RAM ports
  logic              work_we, stor_we;
  logic [IDX_W-1:0]  work_waddr, stor_waddr;
  logic [BYTE_W-1:0] work_wdata, stor_wdata;
  logic [IDX_W-1:0]  work_raddr, stor_raddr;
  logic [BYTE_W-1:0] work_rdata, stor_rdata;

  logic in_xfer;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  shcwb_ram #(.WIDTH(BYTE_W), .DEPTH(IMAGE_BYTES), .AW(IDX_W)) u_work_ram (
    .clk   (clk),
    .we    (work_we),
    .waddr (work_waddr),
    .wdata (work_wdata),
    .raddr (work_raddr),
    .rdata (work_rdata)
  );

  shcwb_ram #(.WIDTH(BYTE_W), .DEPTH(IMAGE_BYTES), .AW(IDX_W)) u_stor_ram (
    .clk   (clk),
    .we    (stor_we),
    .waddr (stor_waddr),
    .wdata (stor_wdata),
    .raddr (stor_raddr),
    .rdata (stor_rdata)
  );

  // Sequencer: next state, RAM controls and result fields.
  always_comb begin
    state_next   = state;
    clr_idx_next = clr_idx;
    pos_next     = pos;
    busy_next    = busy;
    res_next     = res;
    out_load     = 1'b0;

    work_we    = 1'b0;
    work_waddr = idx_r;
    work_wdata = data_r;
    stor_we    = 1'b0;
    stor_waddr = pos;
    stor_wdata = work_rdata;
    work_raddr = pos;
    stor_raddr = pos;

    unique case (state)
      ST_CLEAR: begin
        // erase both copies, one position per cycle
        work_we    = 1'b1;
        work_waddr = clr_idx;
        work_wdata = BYTE_ERASED;
        stor_we    = 1'b1;
        stor_waddr = clr_idx;
        stor_wdata = BYTE_ERASED;
        clr_idx_next = IDX_W'(clr_idx + 1'b1);
        if (clr_idx == LAST_POS) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_xfer) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_next          = '0;
        res_next.busy_res = busy;
        state_next        = ST_FIN;
        unique case (op_r)
          OP_WRITE: begin
            work_we = addr_ok_r;
          end
          OP_STORE: begin
            if (busy) begin
              res_next.status = 1'b1;
            end else begin
              pos_next          = '0;
              busy_next         = 1'b1;
              res_next.busy_res = 1'b1;
            end
          end
          OP_READY: begin
            if (busy) begin
              // first compare reads the current scan position
              state_next = ST_SCAN;
            end
          end
          OP_READ: begin
            stor_raddr = idx_r;
            state_next = ST_READ;
          end
          default: ;
        endcase
      end

      ST_READ: begin
        res_next.read_data = addr_ok_r ? stor_rdata : '0;
        state_next         = ST_FIN;
      end

      ST_SCAN: begin
        if ((work_rdata == stor_rdata) && (pos != LAST_POS)) begin
          // match: fetch the next position straight away
          pos_next   = IDX_W'(pos + 1'b1);
          work_raddr = pos_next;
          stor_raddr = pos_next;
        end else begin
          if (work_rdata != stor_rdata) begin
            stor_we                 = 1'b1;
            res_next.nv_write_valid = 1'b1;
            res_next.nv_write_addr  = ADDR_W'(pos);
            res_next.nv_write_data  = work_rdata;
          end
          if (pos == LAST_POS) begin
            busy_next           = 1'b0;
            res_next.store_done = 1'b1;
            res_next.busy_res   = 1'b0;
          end else begin
            pos_next = IDX_W'(pos + 1'b1);
          end
          state_next = ST_FIN;
        end
      end

      ST_FIN: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  assign out_valid_next = out_load ? 1'b1 : (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      pos       <= '0;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_idx   <= clr_idx_next;
      pos       <= pos_next;
      busy      <= busy_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r      <= op_t'(op);
      idx_r     <= IDX_W'(addr);
      addr_ok_r <= ({1'b0, addr} < (ADDR_W + 1)'(IMAGE_BYTES));
      data_r    <= data;
    end
    res <= res_next;
    if (out_load) begin
      out_res <= res;
    end
  end

  assign status         = out_res.status;
  assign nv_write_valid = out_res.nv_write_valid;
  assign nv_write_addr  = out_res.nv_write_addr;
  assign nv_write_data  = out_res.nv_write_data;
  assign store_done     = out_res.store_done;
  assign busy_res       = out_res.busy_res;
  assign read_data      = out_res.read_data;

endmodule
`default_nettype wire
